>>> rtl/ssbd_pkg.sv
// ----------------------------------------------------------------------------
// Subset-sum bit-row DP: shared types and constants
// Sizes of the row memory, element memory and sequencer state codes.
// ----------------------------------------------------------------------------
package ssbd_pkg;

  localparam int unsigned MaxItems  = 32;
  localparam int unsigned MaxSum    = 1023;
  localparam int unsigned WordBits  = 64;
  localparam int unsigned NWords    = (MaxSum + WordBits) / WordBits;
  localparam int unsigned NRows     = MaxItems + 1;
  localparam int unsigned RowDepth  = NRows * NWords;
  localparam int unsigned ValW      = 10;
  localparam int unsigned CntW      = $clog2(MaxItems + 1);
  localparam int unsigned WordIdxW  = $clog2(NWords);
  localparam int unsigned RowAddrW  = $clog2(RowDepth);
  localparam int unsigned ElemAddrW = $clog2(MaxItems);
  localparam int unsigned BitIdxW   = $clog2(WordBits);

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_SRC,
    ST_UPD_WR,
    ST_TEST_RD,
    ST_TEST_CHK,
    ST_TB_RD,
    ST_TB_CHK,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic              found;
    logic              has_element;
    logic [ValW-1:0]   element_out;
    logic              last_result;
  } result_t;

endpackage

>>> rtl/ssbd_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// Registered read; read data follows the address in the next cycle.
// ----------------------------------------------------------------------------
module ssbd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ssbd_ctrl.sv
// ----------------------------------------------------------------------------
// Subset-sum sequencer
// Builds rows word by word (read, read shift source, shift/OR, write back),
// tests the target and walks the traceback, one row-memory access per step.
// ----------------------------------------------------------------------------
module ssbd_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [ssbd_pkg::ValW-1:0] target_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [ssbd_pkg::ValW-1:0] in_value_i,
  input  logic                   in_last_i,
  output logic                   res_valid_o,
  input  logic                   res_ready_i,
  output ssbd_pkg::result_t      res_o
);
  import ssbd_pkg::*;

  typedef logic [CntW+WordIdxW+1:0] lin_t;

  state_e st_q, st_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [WordIdxW-1:0]  w_q, w_d;
  logic [ValW-1:0]      e_q, e_d;
  logic                 last_q, last_d;
  logic [WordBits-1:0]  carry_q, carry_d;
  logic [WordBits-1:0]  cur_q, cur_d;
  logic [ValW:0]        s_q, s_d;
  logic [CntW-1:0]      c_q, c_d;
  logic                 found_q, found_d;
  result_t              out_q, out_d;
  logic                 ov_q, ov_d;

  logic                 rwe;
  logic [RowAddrW-1:0]  rwa, rra;
  logic [WordBits-1:0]  rwd, rrd;
  logic                 ewe;
  logic [ElemAddrW-1:0] ewa, era;
  logic [ValW-1:0]      erd;

  ssbd_ram #(.Width(WordBits), .Depth(RowDepth)) u_rows (
    .clk_i, .we_i(rwe), .waddr_i(rwa), .wdata_i(rwd), .raddr_i(rra), .rdata_o(rrd)
  );
  ssbd_ram #(.Width(ValW), .Depth(MaxItems)) u_elems (
    .clk_i, .we_i(ewe), .waddr_i(ewa), .wdata_i(e_q), .raddr_i(era), .rdata_o(erd)
  );

  // word shift and carry of previous row shifted by e
  logic [BitIdxW-1:0]   bsh;
  logic [ValW-1:0]      wsh;
  logic [2*WordBits-1:0] sh_full;
  logic [WordBits-1:0]  sh_word, src_word;
  lin_t                 src_lin;
  logic [ValW:0]        s_word;
  logic                 w_in;

  assign bsh = e_q[BitIdxW-1:0];
  assign wsh = e_q >> BitIdxW;
  assign w_in = ({1'b0, w_q} >= wsh[WordIdxW:0]);
  assign sh_full  = {{WordBits{1'b0}}, rrd} << bsh;
  assign src_word = w_in ? sh_full[WordBits-1:0] : '0;
  assign sh_word  = src_word | carry_q;
  assign s_word   = s_q >> BitIdxW;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; w_d = w_q; e_d = e_q; last_d = last_q;
    carry_d = carry_q; cur_d = cur_q; s_d = s_q; c_d = c_q; found_d = found_q;
    out_d = out_q; ov_d = ov_q;
    rwe = 1'b0; rwa = '0; rwd = '0; rra = '0;
    ewe = 1'b0; ewa = cnt_q[ElemAddrW-1:0]; era = '0;
    src_lin = '0;
    in_ready_o = 1'b0;
    if (ov_q && res_ready_i) ov_d = 1'b0;
    unique case (st_q)
      ST_INIT: begin
        rwe = 1'b1;
        rwa = RowAddrW'(w_q);
        rwd = (w_q == '0) ? WordBits'(1) : '0;
        w_d = w_q + 1'b1;
        if (w_q == WordIdxW'(NWords - 1)) begin
          w_d = '0; st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          e_d = in_value_i; last_d = in_last_i; w_d = '0; carry_d = '0;
          if (cnt_q < CntW'(MaxItems)) st_d = ST_UPD_RD;
          else if (in_last_i) st_d = ST_TEST_RD;
        end
      end
      ST_UPD_RD: begin
        src_lin = lin_t'(cnt_q) * lin_t'(NWords) + lin_t'(w_q);
        rra = src_lin[RowAddrW-1:0];
        st_d = ST_UPD_SRC;
      end
      ST_UPD_SRC: begin
        cur_d = rrd;
        src_lin = lin_t'(cnt_q) * lin_t'(NWords) + lin_t'(w_q - wsh[WordIdxW-1:0]);
        rra = src_lin[RowAddrW-1:0];
        st_d = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        rwe = 1'b1;
        src_lin = lin_t'(cnt_q + 1'b1) * lin_t'(NWords) + lin_t'(w_q);
        rwa = src_lin[RowAddrW-1:0];
        rwd = cur_q | ((e_q <= ValW'(MaxSum)) ? sh_word : '0);
        if (w_in)
          carry_d = (bsh == '0) ? '0 : sh_full[2*WordBits-1:WordBits];
        w_d = w_q + 1'b1;
        if (w_q == WordIdxW'(NWords - 1)) begin
          ewe = 1'b1;
          cnt_d = cnt_q + 1'b1;
          w_d = '0;
          st_d = last_q ? ST_TEST_RD : ST_IDLE;
        end else st_d = ST_UPD_RD;
      end
      ST_TEST_RD: begin
        s_d = {1'b0, target_i};
        c_d = cnt_q;
        src_lin = lin_t'(cnt_q) * lin_t'(NWords) + lin_t'(target_i >> BitIdxW);
        rra = src_lin[RowAddrW-1:0];
        st_d = ST_TEST_CHK;
      end
      ST_TEST_CHK: begin
        if (!rrd[s_q[BitIdxW-1:0]] || s_q > (ValW+1)'(MaxSum)) begin
          found_d = 1'b0;
          st_d = ST_EMIT;
        end else begin
          found_d = 1'b1;
          st_d = ST_TB_RD;
        end
      end
      ST_TB_RD: begin
        if (s_q == '0 || c_q == '0) st_d = ST_EMIT;
        else begin
          src_lin = lin_t'(c_q - 1'b1) * lin_t'(NWords) + lin_t'(s_word);
          rra = src_lin[RowAddrW-1:0];
          era = ElemAddrW'(c_q - 1'b1);
          st_d = ST_TB_CHK;
        end
      end
      ST_TB_CHK: begin
        // keep the read addresses so the data survives an output stall
        src_lin = lin_t'(c_q - 1'b1) * lin_t'(NWords) + lin_t'(s_word);
        rra = src_lin[RowAddrW-1:0];
        era = ElemAddrW'(c_q - 1'b1);
        if (!ov_d) begin
          c_d = c_q - 1'b1;
          if (!rrd[s_q[BitIdxW-1:0]]) begin
            s_d = ({1'b0, erd} <= s_q) ? s_q - {1'b0, erd} : '0;
            out_d = '{found: 1'b1, has_element: 1'b1, element_out: erd,
                      last_result: (s_d == '0) || (c_d == '0)};
            ov_d = 1'b1;
            if (out_d.last_result) st_d = ST_INIT;
            else st_d = ST_TB_RD;
          end else st_d = ST_TB_RD;
          if (!rrd[s_q[BitIdxW-1:0]] && out_d.last_result) cnt_d = '0;
        end
      end
      ST_EMIT: begin
        if (!ov_d) begin
          out_d = '{found: found_q, has_element: 1'b0, element_out: '0,
                    last_result: 1'b1};
          ov_d = 1'b1; cnt_d = '0; st_d = ST_INIT;
        end
      end
      default: st_d = ST_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_INIT; cnt_q <= '0; w_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; w_q <= w_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q <= e_d; last_q <= last_d; carry_q <= carry_d; cur_q <= cur_d;
    s_q <= s_d; c_q <= c_d; found_q <= found_d; out_q <= out_d;
  end

  assign res_valid_o = ov_q;
  assign res_o       = out_q;
endmodule

>>> rtl/subset_sum_bitset_dp.sv
// ----------------------------------------------------------------------------
// Subset-sum bit-row dynamic programming block
// Channel  | dir | contents
// s_axis   | in  | tdata: element_value[9:0]; tlast: is_last
// m_axis   | out | tdata: element_out[9:0]; tuser: found, has_element; tlast
// cfg      | in  | target_sum[9:0]
// Each stored element runs a copy read, a shift-source read and a write per
// row word on the single row memory. The last element adds a target test and
// a read and check per traceback row. After reset and after each set, row 0
// is rewritten word by word. A stalled result holds the traceback.
// ----------------------------------------------------------------------------
module subset_sum_bitset_dp (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // element_value[9:0], zero pad
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // element_out[9:0], zero pad
  output logic [1:0]  m_axis_tuser,   // found, has_element
  output logic        m_axis_tlast
);
  import ssbd_pkg::*;

  logic [ValW-1:0] target_q;
  result_t         res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) target_q <= '0;
    else if (cfg_we_i) target_q <= cfg_wdata_i;
  end

  ssbd_ctrl u_ctrl (
    .clk_i, .rst_ni, .target_i(target_q),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_value_i(s_axis_tdata[ValW-1:0]), .in_last_i(s_axis_tlast),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_o(res)
  );

  assign m_axis_tdata = {6'b0, res.element_out};
  assign m_axis_tuser = {res.has_element, res.found};
  assign m_axis_tlast = res.last_result;

  a_has_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.has_element |-> res.found) else $error("element without found");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser) && $stable(m_axis_tlast)) else $error("result changed in stall");
endmodule

>>> tb/sv/subset_sum_bitset_dp_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subset-sum bit-row DP block test
// Streams sets of elements into the block under several target sums and
// checks every traceback result against a bit-row predictor of its own.
// ----------------------------------------------------------------------------

class subset_scoreboard;
  bit [1023:0]        rows[33];
  bit [9:0]           elems[32];
  int unsigned        count;
  bit [9:0]           target;
  ssbd_pkg::result_t  pending[$];
  int unsigned        errors;

  function new();
    count = 0;
    target = 0;
    rows[0] = '0;
    rows[0][0] = 1'b1;
    errors = 0;
  endfunction

  function void note_request(bit [9:0] val, bit last);
    int unsigned s;
    int unsigned c;
    int unsigned k;
    ssbd_pkg::result_t r;
    if (count < ssbd_pkg::MaxItems) begin
      elems[count] = val;
      rows[count + 1] = rows[count] | (rows[count] << val);
      count++;
    end
    if (!last) return;
    s = target;
    k = 0;
    if (!rows[count][s]) begin
      r = '{found: 1'b0, has_element: 1'b0, element_out: '0, last_result: 1'b1};
      pending.push_back(r);
    end else begin
      c = count;
      while (s != 0 && c > 0) begin
        if (!rows[c - 1][s]) begin
          r = '{found: 1'b1, has_element: 1'b1, element_out: elems[c - 1],
                last_result: 1'b0};
          pending.push_back(r);
          k++;
          s = (elems[c - 1] <= s) ? s - elems[c - 1] : 0;
        end
        c--;
      end
      if (k == 0) begin
        r = '{found: 1'b1, has_element: 1'b0, element_out: '0, last_result: 1'b1};
        pending.push_back(r);
      end else begin
        pending[$].last_result = 1'b1;
      end
    end
    count = 0;
  endfunction

  task report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  task check_result(ssbd_pkg::result_t got);
    ssbd_pkg::result_t want;
    if (pending.size() == 0) begin
      report($sformatf("unexpected result %p", got));
      return;
    end
    want = pending.pop_front();
    if (got.found !== want.found)
      report($sformatf("found %0b want %0b", got.found, want.found));
    if (got.has_element !== want.has_element)
      report($sformatf("has_element %0b want %0b", got.has_element, want.has_element));
    if (got.element_out !== want.element_out)
      report($sformatf("element_out %0d want %0d", got.element_out, want.element_out));
    if (got.last_result !== want.last_result)
      report($sformatf("last %0b want %0b", got.last_result, want.last_result));
  endtask
endclass

module subset_sum_bitset_dp_test;
  import ssbd_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [9:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  subset_scoreboard sb;
  bit  quiet_mode;
  int  hold_cycles;
  int  results_seen;

  subset_sum_bitset_dp dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("subset_sum_bitset_dp_test: FAIL");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result('{found: m_axis_tuser[0], has_element: m_axis_tuser[1],
                          element_out: m_axis_tdata[9:0], last_result: m_axis_tlast});
        results_seen++;
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet_mode || ($urandom_range(99) >= 16);
      end
    end
  end

  task automatic send_request(bit [9:0] val, bit last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, val};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(val, last);
    if (!quiet_mode && $urandom_range(99) < 16) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < 16) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (1200) @(posedge clk_i);
  endtask

  task automatic set_target(bit [9:0] t);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= t;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.target = t;
  endtask

  task automatic random_set(int n, int vmax);
    for (int i = 0; i < n; i++)
      send_request(10'($urandom_range(vmax)), i == n - 1);
  endtask

  initial begin
    sb = new();
    quiet_mode = 1'b0;
    hold_cycles = 0;
    results_seen = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (40) @(posedge clk_i);

    // directed: target zero, extremes, element above limit irrelevant (10 bits)
    send_request(10'd0, 1'b1);
    set_target(10'd1023);
    send_request(10'd1023, 1'b1);
    send_request(10'd512, 1'b0);
    send_request(10'd511, 1'b1);
    send_request(10'd1, 1'b1);
    drain();
    set_target(10'd7);
    send_request(10'd3, 1'b0);
    send_request(10'd4, 1'b0);
    send_request(10'd5, 1'b0);
    send_request(10'd2, 1'b1);
    send_request(10'd8, 1'b1);
    // overflow: 40 items, last beyond capacity
    for (int i = 0; i < 40; i++) send_request(10'd1, i == 39);
    drain();

    // long receiver hold-off while sender keeps going
    set_target(10'd100);
    hold_cycles = 3000;
    random_set(12, 60);
    random_set(8, 60);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_target(10'd0);
        1: set_target(10'd1023);
        default: set_target(10'($urandom_range(300)));
      endcase
      quiet_mode = (phase == 3);
      for (int k = 0; k < 10; k++) begin
        if ($urandom_range(9) == 0)
          random_set($urandom_range(33, 36), 1023);
        else if ($urandom_range(2) == 0)
          random_set($urandom_range(1, 8), 1023);
        else
          random_set($urandom_range(1, 8), 80);
      end
      drain();
    end
    quiet_mode = 1'b0;
    drain();
    if (sb.pending.size() != 0)
      sb.report("expected results left over");
    if (sb.errors == 0)
      $display("subset_sum_bitset_dp_test: PASS");
    else
      $display("subset_sum_bitset_dp_test: FAIL");
    $finish;
  end
endmodule
